[rtl/dmmtr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmtr_pkg: shared types and constants
// Widths, reset values, register indexes and the configuration bundle for the
// daily minimum/maximum temperature recorder.
// ----------------------------------------------------------------------------
package dmmtr_pkg;

    localparam int READING_WIDTH = 16;
    localparam int MINUTE_WIDTH  = 11;
    localparam int CFG_IDX_WIDTH = 4;
    localparam int CFG_DATA_WIDTH = READING_WIDTH;

    typedef logic signed [READING_WIDTH-1:0] t_reading;
    typedef logic        [MINUTE_WIDTH-1:0]  t_minute;
    typedef logic        [CFG_IDX_WIDTH-1:0] t_cfg_idx;

    // stamp meaning "no time recorded"
    localparam t_minute NO_TIME = MINUTE_WIDTH'(1440);

    // register indexes
    localparam t_cfg_idx REG_CAL_OFFSET = CFG_IDX_WIDTH'(0);
    localparam t_cfg_idx REG_MIN_VALID  = CFG_IDX_WIDTH'(1);
    localparam t_cfg_idx REG_MAX_VALID  = CFG_IDX_WIDTH'(2);
    localparam t_cfg_idx REG_LOW_MARK   = CFG_IDX_WIDTH'(3);
    localparam t_cfg_idx REG_HIGH_MARK  = CFG_IDX_WIDTH'(4);
    localparam t_cfg_idx REG_INVAL_MARK = CFG_IDX_WIDTH'(5);
    localparam t_cfg_idx REG_MIN_CHANGE = CFG_IDX_WIDTH'(6);
    localparam t_cfg_idx REG_MAX_CHANGE = CFG_IDX_WIDTH'(7);

    // register reset values
    localparam t_reading RST_CAL_OFFSET = READING_WIDTH'(0);
    localparam t_reading RST_MIN_VALID  = READING_WIDTH'(-32766);
    localparam t_reading RST_MAX_VALID  = READING_WIDTH'(32766);
    localparam t_reading RST_LOW_MARK   = READING_WIDTH'(-32767);
    localparam t_reading RST_HIGH_MARK  = READING_WIDTH'(32767);
    localparam t_reading RST_INVAL_MARK = READING_WIDTH'(-32768);
    localparam t_minute  RST_MIN_CHANGE = MINUTE_WIDTH'(540);
    localparam t_minute  RST_MAX_CHANGE = MINUTE_WIDTH'(900);

    typedef struct packed {
        t_reading cal_offset;
        t_reading min_valid;
        t_reading max_valid;
        t_reading low_mark;
        t_reading high_mark;
        t_reading inval_mark;
        t_minute  min_change;
        t_minute  max_change;
    } t_cfg;

endpackage

[rtl/dmmtr_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmtr_cfg: configuration register bank
// Eight write-only registers; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module dmmtr_cfg
    import dmmtr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  t_cfg_idx                  i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_offset <= RST_CAL_OFFSET;
            r_cfg.min_valid  <= RST_MIN_VALID;
            r_cfg.max_valid  <= RST_MAX_VALID;
            r_cfg.low_mark   <= RST_LOW_MARK;
            r_cfg.high_mark  <= RST_HIGH_MARK;
            r_cfg.inval_mark <= RST_INVAL_MARK;
            r_cfg.min_change <= RST_MIN_CHANGE;
            r_cfg.max_change <= RST_MAX_CHANGE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CAL_OFFSET: r_cfg.cal_offset <= i_cfg_data[READING_WIDTH-1:0];
                REG_MIN_VALID:  r_cfg.min_valid  <= i_cfg_data[READING_WIDTH-1:0];
                REG_MAX_VALID:  r_cfg.max_valid  <= i_cfg_data[READING_WIDTH-1:0];
                REG_LOW_MARK:   r_cfg.low_mark   <= i_cfg_data[READING_WIDTH-1:0];
                REG_HIGH_MARK:  r_cfg.high_mark  <= i_cfg_data[READING_WIDTH-1:0];
                REG_INVAL_MARK: r_cfg.inval_mark <= i_cfg_data[READING_WIDTH-1:0];
                REG_MIN_CHANGE: r_cfg.min_change <= i_cfg_data[MINUTE_WIDTH-1:0];
                REG_MAX_CHANGE: r_cfg.max_change <= i_cfg_data[MINUTE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/dmmtr_calib.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmtr_calib: offset and clamp
// Low and high markers pass through; others get the offset in a one-bit-wider
// sum, then saturate to the low or high marker against the valid window.
// ----------------------------------------------------------------------------
module dmmtr_calib
    import dmmtr_pkg::*;
(
    input  t_reading i_raw,
    input  t_cfg     i_cfg,
    output t_reading o_value
);

    logic signed [READING_WIDTH:0] w_sum;
    logic signed [READING_WIDTH:0] w_lo;
    logic signed [READING_WIDTH:0] w_hi;

    // window bounds lie inside the reading range, so the sum needs no extra check
    assign w_sum = {i_raw[READING_WIDTH-1], i_raw}
                 + {i_cfg.cal_offset[READING_WIDTH-1], i_cfg.cal_offset};
    assign w_lo  = {i_cfg.min_valid[READING_WIDTH-1], i_cfg.min_valid};
    assign w_hi  = {i_cfg.max_valid[READING_WIDTH-1], i_cfg.max_valid};

    always_comb begin
        if (i_raw == i_cfg.low_mark || i_raw == i_cfg.high_mark) begin
            o_value = i_raw;
        end else if (w_sum < w_lo) begin
            o_value = i_cfg.low_mark;
        end else if (w_sum > w_hi) begin
            o_value = i_cfg.high_mark;
        end else begin
            o_value = w_sum[READING_WIDTH-1:0];
        end
    end

endmodule

[rtl/dmmtr_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmtr_track: one extreme record (today and yesterday)
// Rolls today into yesterday on the first beat of the changeover minute,
// then replaces today when empty or beaten.
// ----------------------------------------------------------------------------
module dmmtr_track
    import dmmtr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_lowest,
    input  logic     i_new_minute,
    input  t_minute  i_change,
    input  t_minute  i_now,
    input  t_reading i_value,
    input  t_reading i_inval_mark,
    output t_reading o_today,
    output t_minute  o_today_time,
    output t_reading o_yday,
    output t_minute  o_yday_time
);

    t_reading r_today, n_today;
    t_minute  r_today_t, n_today_t;
    t_reading r_yday, n_yday;
    t_minute  r_yday_t, n_yday_t;

    logic     w_shift;
    logic     w_beats;
    t_reading w_cur;
    t_minute  w_cur_t;

    assign w_shift = (i_now == i_change) && i_new_minute;

    always_comb begin
        w_cur   = w_shift ? i_inval_mark : r_today;
        w_cur_t = w_shift ? NO_TIME : r_today_t;
        n_yday   = w_shift ? r_today : r_yday;
        n_yday_t = w_shift ? r_today_t : r_yday_t;
        w_beats  = i_lowest ? (i_value < w_cur) : (i_value > w_cur);
        if (w_cur == i_inval_mark || w_beats) begin
            n_today   = i_value;
            n_today_t = i_now;
        end else begin
            n_today   = w_cur;
            n_today_t = w_cur_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_today   <= RST_INVAL_MARK;
            r_today_t <= NO_TIME;
            r_yday    <= RST_INVAL_MARK;
            r_yday_t  <= NO_TIME;
        end else if (i_en) begin
            r_today   <= n_today;
            r_today_t <= n_today_t;
            r_yday    <= n_yday;
            r_yday_t  <= n_yday_t;
        end
    end

    assign o_today      = r_today;
    assign o_today_time = r_today_t;
    assign o_yday       = r_yday;
    assign o_yday_time  = r_yday_t;

endmodule

[rtl/daily_min_max_temperature_recorder.sv]
`timescale 1ns / 1ps
// Path: an accepted input beat reaches its result beat through the input register,
//   then calibrate + record update into the result register.
// Throughput: one beat per cycle while the result channel is not stalled.
// Reset: synchronous, active low; registers return to defaults, all records
//   empty (invalid marker, time 1440), no previous minute.
// ----------------------------------------------------------------------------
// daily_min_max_temperature_recorder: top level
// Calibrates each sensor reading and keeps today's and yesterday's minimum
// and maximum with their minutes of day.
// ----------------------------------------------------------------------------
module daily_min_max_temperature_recorder
    import dmmtr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration
    input  logic                      i_cfg_we,
    input  t_cfg_idx                  i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_reading                  i_raw_reading,
    input  t_minute                   i_time_of_day,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_reading                  o_calibrated_reading,
    output t_reading                  o_max_today,
    output t_minute                   o_max_today_time,
    output t_reading                  o_min_today,
    output t_minute                   o_min_today_time,
    output t_reading                  o_max_yesterday,
    output t_minute                   o_max_yesterday_time,
    output t_reading                  o_min_yesterday,
    output t_minute                   o_min_yesterday_time
);

    t_cfg     w_cfg;

    // input register
    logic     r_s1_valid;
    t_reading r_s1_raw;
    t_minute  r_s1_time;

    // result register; the record registers inside the trackers form the
    // rest of the result and only change when a new beat is loaded here
    logic     r_out_valid;
    t_reading r_cal;
    t_minute  r_prev_min;

    logic     w_in_acc;
    logic     w_out_acc;
    logic     w_adv;
    logic     w_new_minute;
    t_reading w_cal;

    dmmtr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // the input stage moves on when the result register is empty or draining
    assign w_adv      = r_s1_valid & (~r_out_valid | ~i_out_stall);
    assign o_in_stall = r_s1_valid & ~w_adv;
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_acc  = r_out_valid & ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_raw  <= i_raw_reading;
            r_s1_time <= i_time_of_day;
        end
    end

    dmmtr_calib u_calib (
        .i_raw   (r_s1_raw),
        .i_cfg   (w_cfg),
        .o_value (w_cal)
    );

    // a changeover fires only on the first beat that arrives in its minute
    assign w_new_minute = (r_s1_time != r_prev_min);

    dmmtr_track u_min (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_lowest     (1'b1),
        .i_new_minute (w_new_minute),
        .i_change     (w_cfg.min_change),
        .i_now        (r_s1_time),
        .i_value      (w_cal),
        .i_inval_mark (w_cfg.inval_mark),
        .o_today      (o_min_today),
        .o_today_time (o_min_today_time),
        .o_yday       (o_min_yesterday),
        .o_yday_time  (o_min_yesterday_time)
    );

    dmmtr_track u_max (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_adv),
        .i_lowest     (1'b0),
        .i_new_minute (w_new_minute),
        .i_change     (w_cfg.max_change),
        .i_now        (r_s1_time),
        .i_value      (w_cal),
        .i_inval_mark (w_cfg.inval_mark),
        .o_today      (o_max_today),
        .o_today_time (o_max_today_time),
        .o_yday       (o_max_yesterday),
        .o_yday_time  (o_max_yesterday_time)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev_min  <= NO_TIME;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_prev_min  <= r_s1_time;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_cal <= w_cal;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_calibrated_reading = r_cal;

endmodule
